[rtl/core/bcpg_pkg.sv]
// Package for the Bezier curve point generator: widths, formats, register
// indexes, sequencer states and the control bundle. No dependencies.
`timescale 1ns / 1ps

package bcpg_pkg;

  // coordinates signed Q5.16, t unsigned with T_FRACTION_BITS fraction bits
  localparam int COORD_WIDTH     = 22;
  localparam int T_FRACTION_BITS = 20;
  localparam int STEP_W          = 21;
  localparam int DEG_W           = 2;
  localparam int CFG_ADDR_W      = 2;
  localparam int NUM_PTS         = 4;
  localparam int K_W             = 2;

  localparam int POS_W  = T_FRACTION_BITS + 2;
  localparam int NT_W   = ((POS_W > STEP_W) ? POS_W : STEP_W) + 1;
  localparam int PROD_W = COORD_WIDTH + T_FRACTION_BITS + 3;

  localparam int PT_LSB      = DEG_W;
  localparam int IN_TDATA_W  = ((DEG_W + 2 * NUM_PTS * COORD_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * COORD_WIDTH + 7) / 8) * 8;

  localparam logic [NT_W-1:0]   T_ONE   = NT_W'(1) << T_FRACTION_BITS;
  localparam logic [NT_W-1:0]   POS_MAX = NT_W'({POS_W{1'b1}});
  localparam logic [PROD_W-1:0] T_HALF  = PROD_W'(1) << (T_FRACTION_BITS - 1);

  localparam logic [STEP_W-1:0] LINE_STEP_RST = STEP_W'(157);
  localparam logic [STEP_W-1:0] QUAD_STEP_RST = STEP_W'(524);
  localparam logic [STEP_W-1:0] CUBE_STEP_RST = STEP_W'(105);

  localparam logic [CFG_ADDR_W-1:0] REG_LINE_STEP = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_QUAD_STEP = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] REG_CUBE_STEP = CFG_ADDR_W'(2);

  localparam logic CMD_START = 1'b0;

  localparam logic [DEG_W-1:0] DEG_NONE      = DEG_W'(0);
  localparam logic [DEG_W-1:0] DEG_LINE      = DEG_W'(1);
  localparam logic [DEG_W-1:0] DEG_QUADRATIC = DEG_W'(2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_ACC,
    ST_FIN
  } bcpg_state_t;

  typedef struct packed {
    logic           in_ready;
    logic           load_work;
    logic           coord;
    logic           mul_en;
    logic [K_W-1:0] k;
    logic           acc_we;
    logic           coord_done;
    logic           fin;
  } bcpg_ctl_t;

endpackage

[rtl/core/bcpg_interp.sv]
// Shared interpolation unit: a + round((b - a) * t), multiply then accumulate.
// Depends on bcpg_pkg.
`timescale 1ns / 1ps

module bcpg_interp (
  input  logic                                      clk,
  input  logic                                      mul_en,
  input  logic signed [bcpg_pkg::COORD_WIDTH-1:0]   a,
  input  logic signed [bcpg_pkg::COORD_WIDTH-1:0]   b,
  input  logic        [bcpg_pkg::T_FRACTION_BITS:0] t,
  output logic signed [bcpg_pkg::COORD_WIDTH-1:0]   res
);

  logic signed [bcpg_pkg::COORD_WIDTH:0]   diff;
  logic signed [bcpg_pkg::PROD_W-1:0]      mul_a;
  logic signed [bcpg_pkg::PROD_W-1:0]      mul_b;
  logic signed [bcpg_pkg::PROD_W-1:0]      prod_nxt;
  logic signed [bcpg_pkg::PROD_W-1:0]      prod_r;
  logic signed [bcpg_pkg::COORD_WIDTH-1:0] a_r;
  logic signed [bcpg_pkg::PROD_W-1:0]      sum;
  logic signed [bcpg_pkg::PROD_W-1:0]      q;

  always_comb begin
    diff     = (bcpg_pkg::COORD_WIDTH + 1)'(b) - (bcpg_pkg::COORD_WIDTH + 1)'(a);
    mul_a    = bcpg_pkg::PROD_W'(diff);
    mul_b    = $signed(bcpg_pkg::PROD_W'(t));
    prod_nxt = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= prod_nxt;
      a_r    <= a;
    end
  end

  // arithmetic shift gives floor, so adding half first rounds half up
  always_comb begin
    sum = prod_r + $signed(bcpg_pkg::T_HALF);
    q   = sum >>> bcpg_pkg::T_FRACTION_BITS;
    res = a_r + $signed(q[bcpg_pkg::COORD_WIDTH-1:0]);
  end

endmodule

[rtl/core/bcpg_ctrl.sv]
// Sequencer for the generator: walks de Casteljau levels over x then y,
// driving the shared interpolation unit. Depends on bcpg_pkg.
`timescale 1ns / 1ps

module bcpg_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_fire,
  input  logic                            cmd_start,
  input  logic                            done_r,
  input  logic [bcpg_pkg::DEG_W-1:0]      degree,
  input  logic                            out_free,
  output bcpg_pkg::bcpg_ctl_t             ctl
);

  bcpg_pkg::bcpg_state_t            state_r, state_nxt;
  logic [bcpg_pkg::DEG_W-1:0]       lvl_r, lvl_nxt;
  logic [bcpg_pkg::K_W-1:0]         k_r, k_nxt;
  logic                             coord_r, coord_nxt;
  logic                             lvl_end;

  assign lvl_end = (k_r == bcpg_pkg::K_W'(lvl_r - 1'b1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bcpg_pkg::ST_IDLE: begin
        if (in_fire && (cmd_start || !done_r)) state_nxt = bcpg_pkg::ST_LOAD;
      end
      bcpg_pkg::ST_LOAD: state_nxt = bcpg_pkg::ST_MUL;
      bcpg_pkg::ST_MUL:  state_nxt = bcpg_pkg::ST_ACC;
      bcpg_pkg::ST_ACC: begin
        if (lvl_end && lvl_r == bcpg_pkg::DEG_LINE)
          state_nxt = coord_r ? bcpg_pkg::ST_FIN : bcpg_pkg::ST_LOAD;
        else
          state_nxt = bcpg_pkg::ST_MUL;
      end
      bcpg_pkg::ST_FIN: begin
        if (out_free) state_nxt = bcpg_pkg::ST_IDLE;
      end
      default: state_nxt = bcpg_pkg::ST_IDLE;
    endcase
  end

  // counters
  always_comb begin
    lvl_nxt   = lvl_r;
    k_nxt     = k_r;
    coord_nxt = coord_r;
    case (state_r)
      bcpg_pkg::ST_IDLE: coord_nxt = 1'b0;
      bcpg_pkg::ST_LOAD: begin
        lvl_nxt = degree;
        k_nxt   = '0;
      end
      bcpg_pkg::ST_ACC: begin
        if (lvl_end) begin
          k_nxt   = '0;
          lvl_nxt = lvl_r - 1'b1;
          if (lvl_r == bcpg_pkg::DEG_LINE) coord_nxt = 1'b1;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    ctl            = '0;
    ctl.k          = k_r;
    ctl.coord      = coord_r;
    case (state_r)
      bcpg_pkg::ST_IDLE: ctl.in_ready  = 1'b1;
      bcpg_pkg::ST_LOAD: ctl.load_work = 1'b1;
      bcpg_pkg::ST_MUL:  ctl.mul_en    = 1'b1;
      bcpg_pkg::ST_ACC: begin
        ctl.acc_we     = 1'b1;
        ctl.coord_done = lvl_end && (lvl_r == bcpg_pkg::DEG_LINE);
      end
      bcpg_pkg::ST_FIN:  ctl.fin       = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bcpg_pkg::ST_IDLE;
      lvl_r   <= bcpg_pkg::DEG_LINE;
      k_r     <= '0;
      coord_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lvl_r   <= lvl_nxt;
      k_r     <= k_nxt;
      coord_r <= coord_nxt;
    end
  end

endmodule

[rtl/core/bezier_curve_point_generator.sv]
// Top level of the Bezier curve point generator: step registers, control
// points, curve state, output register. Depends on bcpg_pkg, bcpg_ctrl, bcpg_interp.
//
//   channel | dir | beat contents
//   in_     | in  | tuser: command; tdata: degree, px0, py0, px1, py1, px2, py2, px3, py3
//   out_    | out | tdata: point_x, point_y; tlast: last_point
//   cfg_    | in  | write of a step register (line, quadratic, cubic)
//
// A point of degree d takes d*(d+1) interpolations on the one shared multiplier,
// each a multiply step then an accumulate step, x levels first, then y.
// A next beat with no active curve is taken and produces nothing.
// in_tready is high only while the sequencer is idle; a point waiting on
// out_tready does not block the next input beat, only the following result.
// Reset (rst_n, synchronous) restores the step defaults and ends any curve.
`timescale 1ns / 1ps

module bezier_curve_point_generator (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [bcpg_pkg::IN_TDATA_W-1:0]    in_tdata,   // degree, px0, py0 .. px3, py3
  input  logic                               in_tuser,   // command
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [bcpg_pkg::OUT_TDATA_W-1:0]   out_tdata,  // point_x, point_y
  output logic                               out_tlast,
  input  logic                               cfg_we,
  input  logic [bcpg_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [bcpg_pkg::STEP_W-1:0]        cfg_wdata
);

  localparam int CW = bcpg_pkg::COORD_WIDTH;

  bcpg_pkg::bcpg_ctl_t ctl;

  logic [bcpg_pkg::STEP_W-1:0] line_step_r, quad_step_r, cube_step_r;
  logic [bcpg_pkg::DEG_W-1:0]  deg_r, deg_in;
  logic [bcpg_pkg::POS_W-1:0]  pos_r;
  logic                        done_r;
  logic signed [CW-1:0]        cx_r [bcpg_pkg::NUM_PTS];
  logic signed [CW-1:0]        cy_r [bcpg_pkg::NUM_PTS];
  logic signed [CW-1:0]        w_r  [bcpg_pkg::NUM_PTS];
  logic signed [CW-1:0]        px_r;
  logic signed [CW-1:0]        op_a, op_b, res;
  logic                        in_fire, cmd_start, out_free;
  logic [bcpg_pkg::STEP_W-1:0] step;
  logic [bcpg_pkg::NT_W-1:0]   nt;
  logic                        last_w;
  logic                        out_valid_r;
  logic signed [CW-1:0]        out_x_r, out_y_r;
  logic                        out_last_r;

  assign in_fire   = in_tvalid && in_tready;
  assign cmd_start = (in_tuser == bcpg_pkg::CMD_START);
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = ctl.in_ready;
  assign deg_in    = in_tdata[bcpg_pkg::DEG_W-1:0];

  bcpg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .cmd_start (cmd_start),
    .done_r    (done_r),
    .degree    (deg_r),
    .out_free  (out_free),
    .ctl       (ctl)
  );

  // operand pair (k, k+1) for the current level
  always_comb begin
    case (ctl.k)
      2'd0:    begin op_a = w_r[0]; op_b = w_r[1]; end
      2'd1:    begin op_a = w_r[1]; op_b = w_r[2]; end
      default: begin op_a = w_r[2]; op_b = w_r[3]; end
    endcase
  end

  bcpg_interp u_interp (
    .clk    (clk),
    .mul_en (ctl.mul_en),
    .a      (op_a),
    .b      (op_b),
    .t      (pos_r[bcpg_pkg::T_FRACTION_BITS:0]),
    .res    (res)
  );

  // step for the active degree, zero counts as one
  always_comb begin
    case (deg_r)
      bcpg_pkg::DEG_LINE:      step = line_step_r;
      bcpg_pkg::DEG_QUADRATIC: step = quad_step_r;
      default:                 step = cube_step_r;
    endcase
    if (step == '0) step = bcpg_pkg::STEP_W'(1);
    nt     = bcpg_pkg::NT_W'(pos_r) + bcpg_pkg::NT_W'(step);
    last_w = (nt > bcpg_pkg::T_ONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_step_r <= bcpg_pkg::LINE_STEP_RST;
      quad_step_r <= bcpg_pkg::QUAD_STEP_RST;
      cube_step_r <= bcpg_pkg::CUBE_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        bcpg_pkg::REG_LINE_STEP: line_step_r <= cfg_wdata;
        bcpg_pkg::REG_QUAD_STEP: quad_step_r <= cfg_wdata;
        bcpg_pkg::REG_CUBE_STEP: cube_step_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // curve state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_r  <= bcpg_pkg::DEG_LINE;
      pos_r  <= '0;
      done_r <= 1'b1;
    end else if (in_fire && cmd_start) begin
      deg_r  <= (deg_in == bcpg_pkg::DEG_NONE) ? bcpg_pkg::DEG_LINE : deg_in;
      pos_r  <= '0;
      done_r <= 1'b0;
    end else if (ctl.fin && out_free) begin
      pos_r <= (nt > bcpg_pkg::POS_MAX) ? bcpg_pkg::POS_MAX[bcpg_pkg::POS_W-1:0]
                                        : nt[bcpg_pkg::POS_W-1:0];
      if (last_w) done_r <= 1'b1;
    end
  end

  // control points and working set
  always_ff @(posedge clk) begin
    if (in_fire && cmd_start) begin
      for (int j = 0; j < bcpg_pkg::NUM_PTS; j++) begin
        cx_r[j] <= in_tdata[bcpg_pkg::PT_LSB + 2 * j * CW +: CW];
        cy_r[j] <= in_tdata[bcpg_pkg::PT_LSB + (2 * j + 1) * CW +: CW];
      end
    end
    if (ctl.load_work) begin
      for (int j = 0; j < bcpg_pkg::NUM_PTS; j++)
        w_r[j] <= ctl.coord ? cy_r[j] : cx_r[j];
    end else if (ctl.acc_we) begin
      case (ctl.k)
        2'd0:    w_r[0] <= res;
        2'd1:    w_r[1] <= res;
        default: w_r[2] <= res;
      endcase
    end
    if (ctl.coord_done && !ctl.coord) px_r <= res;
  end

  // output register; y sits in w_r[0] once the last level is done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.fin && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fin && out_free) begin
      out_x_r    <= px_r;
      out_y_r    <= w_r[0];
      out_last_r <= last_w;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = bcpg_pkg::OUT_TDATA_W'({out_y_r, out_x_r});
  assign out_tlast  = out_last_r;

  a_fin_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fin && out_free |=> out_valid_r)
    else $error("finished point not registered for output");

  a_last_ends_curve: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fin && out_free && last_w |=> done_r)
    else $error("last point did not end the curve");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !done_r |-> (bcpg_pkg::NT_W'(pos_r) <= bcpg_pkg::T_ONE))
    else $error("active curve position beyond one");

  a_unit_idle_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !ctl.mul_en && !ctl.acc_we && !ctl.fin)
    else $error("input ready while the shared unit is busy");

endmodule
